### rtl/ofrm_pkg.sv
package ofrm_pkg;

    localparam int CAPACITY  = 8;
    localparam int VAL_W     = 8;
    localparam int CNT_OUT_W = 4;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SUM_W     = $clog2(255 * CAPACITY + 1);
    localparam int DIVD_W    = SUM_W + 1;
    localparam int DIVR_W    = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [VAL_W-1:0] t_val;

    localparam t_cnt CAP_CNT  = CNT_W'(CAPACITY);
    localparam t_idx LAST_IDX = IDX_W'(CAPACITY - 1);

    // Operation handed to the queue store.
    typedef struct packed {
        logic func;
        t_val value;
    } t_q_cmd;

    // Queue state after the operation, plus what the operation returns.
    typedef struct packed {
        t_sum sum;
        t_cnt occ;
        t_val removed;
        logic error;
    } t_q_next;

    typedef struct packed {
        t_val                 mean;
        t_val                 removed_value;
        logic                 error;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

    function automatic t_idx ofrm_inc(input t_idx idx);
        return (idx == LAST_IDX) ? '0 : idx + t_idx'(1);
    endfunction

    function automatic t_idx ofrm_wrap_add(input t_idx a, input t_idx b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W + 1)'(CAPACITY)) begin
            s = s - (IDX_W + 1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

### rtl/ofrm_if.sv
interface ofrm_in_if;
    import ofrm_pkg::*;
    logic valid;
    logic ready;
    logic func;
    t_val value;
    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface ofrm_out_if;
    import ofrm_pkg::*;
    logic                 valid;
    logic                 ready;
    t_val                 mean;
    t_val                 removed_value;
    logic                 error;
    logic [CNT_OUT_W-1:0] count;
    modport source (output valid, output mean, output removed_value, output error,
                    output count, input ready);
    modport sink   (input valid, input mean, input removed_value, input error,
                    input count, output ready);
endinterface

### rtl/ofrm_queue.sv
module ofrm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd,
    input  logic             i_upd,
    input  ofrm_pkg::t_q_cmd i_cmd,
    output ofrm_pkg::t_q_next o_next
);
    import ofrm_pkg::*;

    t_val r_mem [CAPACITY];
    t_val r_rd_data;
    t_idx r_head;
    t_idx n_head;
    t_cnt r_occ;
    t_sum r_sum;
    t_idx tail;
    logic full;
    logic empty;
    logic wr_en;

    // Read data holds the oldest entry, fetched when the item was taken.
    always_comb begin
        full   = (r_occ == CAP_CNT);
        empty  = (r_occ == '0);
        n_head = r_head;
        wr_en  = 1'b0;
        tail   = ofrm_wrap_add(r_head, r_occ[IDX_W-1:0]);
        o_next = '0;
        o_next.sum = r_sum;
        o_next.occ = r_occ;
        if (i_cmd.func == FUNC_INSERT) begin
            wr_en = 1'b1;
            if (full) begin
                // The oldest slot is dropped and reused for the new value.
                n_head     = ofrm_inc(r_head);
                tail       = r_head;
                o_next.sum = r_sum - SUM_W'(r_rd_data) + SUM_W'(i_cmd.value);
            end else begin
                o_next.sum = r_sum + SUM_W'(i_cmd.value);
                o_next.occ = r_occ + t_cnt'(1);
            end
        end else if (empty) begin
            o_next.error = 1'b1;
        end else begin
            n_head         = ofrm_inc(r_head);
            o_next.occ     = r_occ - t_cnt'(1);
            o_next.sum     = r_sum - SUM_W'(r_rd_data);
            o_next.removed = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && wr_en) begin
            r_mem[tail] <= i_cmd.value;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
            r_sum  <= '0;
        end else if (i_upd) begin
            r_head <= n_head;
            r_occ  <= o_next.occ;
            r_sum  <= o_next.sum;
        end
    end

endmodule

### rtl/ofrm_div.sv
module ofrm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ofrm_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [ofrm_pkg::DIVR_W-1:0]   i_divisor,
    output logic                          o_done,
    output ofrm_pkg::t_val                o_quot
);
    import ofrm_pkg::*;

    logic [DIVD_W-1:0]    r_dvd;
    logic [DIVD_W-1:0]    r_quot;
    logic [DIVR_W-1:0]    r_dvsr;
    logic [DIVR_W-1:0]    r_rem;
    logic [DIVR_W-1:0]    n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic                 ge;

    // One restoring step per cycle while busy: bring in the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvsr};
        ge    = (trial >= {1'b0, r_dvsr});
        n_rem = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvsr <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DIVD_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIVD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[VAL_W-1:0];

endmodule

### rtl/overwrite_fifo_rounded_mean.sv
// One item at a time: the input is not ready again until the result has moved to the output register.
// An insert waits for the bit-serial divider, one quotient bit per cycle (12 bits); a remove does not.
// Reset (synchronous, active low) empties the queue: head, count and sum return to zero.
// The value store itself is not cleared; only slots that hold a value are ever used.
module overwrite_fifo_rounded_mean (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ofrm_in_if.sink      i_in,
    ofrm_out_if.source   o_out
);
    import ofrm_pkg::*;

    // Control sequence for one item:
    //   S_IDLE: take a transfer and fetch the oldest entry from the store.
    //   S_UPD : read-modify-write of the store and of head, count and sum.
    //   S_DIV : an insert waits here for the rounded mean.
    //   S_OUT : the result moves into the output register once it is free.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_q_cmd            r_cmd;
    t_q_next           q_next;
    t_result           r_res;
    t_result           r_out;
    logic              r_out_valid;
    logic              accept;
    logic              upd;
    logic              div_start;
    logic              div_done;
    t_val              div_quot;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
    logic              out_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign upd        = (r_state == S_UPD);
    assign div_start  = upd && (r_cmd.func == FUNC_INSERT);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // The store is read at the head on the transfer, so its registered data
    // is ready for the update in the following cycle.
    ofrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (accept),
        .i_upd   (upd),
        .i_cmd   (r_cmd),
        .o_next  (q_next)
    );

    // Rounding half up: mean = floor((2*sum + n) / (2*n)).
    assign dividend = {q_next.sum, 1'b0} + DIVD_W'(q_next.occ);
    assign divisor  = {q_next.occ, 1'b0};

    ofrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = (r_cmd.func == FUNC_INSERT) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item and result holding registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.func  <= i_in.func;
            r_cmd.value <= i_in.value;
        end
        if (upd) begin
            // Every field but the mean is known once the store is updated.
            r_res.mean          <= '0;
            r_res.removed_value <= q_next.removed;
            r_res.error         <= q_next.error;
            r_res.count         <= CNT_OUT_W'(q_next.occ);
        end else if ((r_state == S_DIV) && div_done) begin
            r_res.mean <= div_quot;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // The output register lets a finished result wait while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mean          = r_out.mean;
    assign o_out.removed_value = r_out.removed_value;
    assign o_out.error         = r_out.error;
    assign o_out.count         = r_out.count;

endmodule

### rtl/ofrm_checker.sv
module ofrm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  ofrm_pkg::t_val                 i_out_mean,
    input  ofrm_pkg::t_val                 i_out_removed_value,
    input  logic                           i_out_error,
    input  logic [ofrm_pkg::CNT_OUT_W-1:0] i_out_count
);
    import ofrm_pkg::*;

    // A failed remove reports an empty queue and nothing else.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |->
            i_out_mean == '0 && i_out_removed_value == '0 && i_out_count == '0)
        else $error("error result carries nonzero fields");

    // A popped value only comes from a remove, which never reports a mean.
    a_remove_no_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_removed_value != '0 |-> i_out_mean == '0 && !i_out_error)
        else $error("remove result carries a mean or an error");

    // Items are worked on one at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mean)
            && $stable(i_out_removed_value) && $stable(i_out_error) && $stable(i_out_count))
        else $error("stalled result changed");

endmodule

bind overwrite_fifo_rounded_mean ofrm_checker u_ofrm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_mean          (o_out.mean),
    .i_out_removed_value (o_out.removed_value),
    .i_out_error         (o_out.error),
    .i_out_count         (o_out.count)
);

### sim/overwrite_fifo_rounded_mean_tb.sv
`timescale 1ns / 1ps

module overwrite_fifo_rounded_mean_tb;
    import ofrm_pkg::*;

    // Generous cycle budget for about 1700 transfers, plus sender gaps, receiver stalls
    // and two long hold-offs, taken several times over.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 300;
    // The slowest result comes from an insert.
    localparam int DRAIN_CYCLES = 40;

    // Tracks the queue contents the block should hold and the results it owes.
    class fifo_mean_tracker;
        t_val    held_values[CAPACITY];
        int      oldest;
        int      occupancy;
        int      value_sum;
        t_result pending_results[$];
        int      mismatches;

        function new();
            oldest     = 0;
            occupancy  = 0;
            value_sum  = 0;
            mismatches = 0;
        endfunction

        function t_val drop_oldest();
            t_val v;
            v         = held_values[oldest];
            oldest    = (oldest + 1) % CAPACITY;
            occupancy = occupancy - 1;
            value_sum = value_sum - int'(v);
            return v;
        endfunction

        // Called for every accepted input transfer; queues the result it must cause.
        function void record_transfer(logic func, t_val value);
            t_result want;
            want = '0;
            if (func == FUNC_INSERT) begin
                if (occupancy >= CAPACITY) begin
                    void'(drop_oldest());
                end
                held_values[(oldest + occupancy) % CAPACITY] = value;
                occupancy = occupancy + 1;
                value_sum = value_sum + int'(value);
                // Round half up, exactly in integers.
                want.mean = t_val'((2 * value_sum + occupancy) / (2 * occupancy));
            end else if (occupancy == 0) begin
                want.error = 1'b1;
            end else begin
                want.removed_value = drop_oldest();
            end
            want.count = CNT_OUT_W'(occupancy);
            pending_results.push_back(want);
        endfunction

        // Called for every accepted output transfer; compares it with the oldest expectation.
        function void compare_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result mean=%0d removed=%0d error=%0b count=%0d",
                         $time, got.mean, got.removed_value, got.error, got.count);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected mean=%0d removed=%0d error=%0b count=%0d",
                         $time, want.mean, want.removed_value, want.error, want.count);
                $display("%0t:          actual   mean=%0d removed=%0d error=%0b count=%0d",
                         $time, got.mean, got.removed_value, got.error, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   hold_request = 1'b0;
    int   cycles;

    fifo_mean_tracker tracker = new();

    ofrm_in_if  in_ch();
    ofrm_out_if out_ch();

    overwrite_fifo_rounded_mean DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running 2 ns clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offers one item starting at the next falling edge and holds it until the
    // rising edge at which the transfer happens. Valid stays high on return so
    // that back-to-back items see no gap.
    task automatic offer_item(input logic func, input t_val value);
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.func  = func;
        in_ch.value = value;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        tracker.record_transfer(func, value);
    endtask

    // Sender gap: valid low for the given number of cycles, with junk on the payload.
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            in_ch.func  = 1'($urandom);
            in_ch.value = t_val'($urandom);
        end
    endtask

    // Random payload value, with the two extremes drawn more often than chance.
    function automatic t_val pick_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return t_val'(0);
        end else if (pick == 1) begin
            return t_val'(255);
        end
        return t_val'($urandom_range(0, 255));
    endfunction

    // Receiver: switches between random stall patterns and, when
    // asked, holds ready low for a long stretch so the block backs up and
    // stalls its input side.
    initial begin : receiver
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(32, 256);
                end
                left--;
                case (mode)
                    0: begin
                        out_ch.ready = 1'b1;
                    end
                    1: begin
                        out_ch.ready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        out_ch.ready = ((tick % 4) != 3);
                    end
                    default: begin
                        out_ch.ready = ($urandom_range(0, 2) == 0);
                    end
                endcase
            end
        end
    end

    // Result monitor: every output transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.mean          = out_ch.mean;
            got.removed_value = out_ch.removed_value;
            got.error         = out_ch.error;
            got.count         = out_ch.count;
            tracker.compare_result(got);
        end
    end

    // Main stimulus.
    initial begin : stimulus
        int   remaining;
        int   burst;
        int   insert_pct;
        int   phase_left;
        bit   gapless;
        logic func;
        in_ch.valid = 1'b0;
        in_ch.func  = FUNC_INSERT;
        in_ch.value = '0;
        i_rst_n     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A remove on the empty queue must flag an error.
        offer_item(FUNC_REMOVE, t_val'(8'h3C));
        // Extreme values; the mean of 0 and 255 is an exact half and rounds up.
        offer_item(FUNC_INSERT, t_val'(0));
        offer_item(FUNC_INSERT, t_val'(255));
        offer_item(FUNC_REMOVE, t_val'(0));
        offer_item(FUNC_REMOVE, t_val'(255));
        // Empty again after draining: a second error.
        offer_item(FUNC_REMOVE, t_val'(0));
        // Fill to capacity with the largest value, giving the largest sum.
        repeat (CAPACITY) offer_item(FUNC_INSERT, t_val'(255));
        // Inserts into the full queue silently drop the oldest entry.
        offer_item(FUNC_INSERT, t_val'(0));
        offer_item(FUNC_INSERT, t_val'(8'hAA));
        offer_item(FUNC_INSERT, t_val'(8'h55));
        // Drain completely and try once more past empty.
        repeat (CAPACITY + 1) offer_item(FUNC_REMOVE, t_val'(8'hFF));
        idle_for(3);

        // Random part: bursts with gaps, in phases that lean toward filling,
        // toward draining, or stay balanced, so the queue sweeps from empty
        // through full and overflow many times.
        remaining  = RANDOM_ITEMS;
        phase_left = 0;
        insert_pct = 50;
        gapless    = 1'b0;
        while (remaining > 0) begin
            if (phase_left <= 0) begin
                phase_left = $urandom_range(40, 150);
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 30;
                    default: insert_pct = 55;
                endcase
                gapless = ($urandom_range(0, 3) == 0);
            end
            // Two long receiver hold-offs while the sender keeps offering items.
            if (remaining == 1200 || remaining == 400) begin
                hold_request = 1'b1;
            end
            burst = $urandom_range(1, 12);
            if (burst > remaining) begin
                burst = remaining;
            end
            repeat (burst) begin
                func = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
                offer_item(func, pick_value());
                remaining--;
                phase_left--;
                if (remaining == 1200 || remaining == 400) begin
                    hold_request = 1'b1;
                end
            end
            if (!gapless && $urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 20));
            end
        end
        idle_for(1);

        // Wait for every owed result, then a little longer for stray ones.
        while (tracker.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
